[design/bsws_pkg.sv]
// ----------------------------------------------------------------------------
// bsws_pkg: shared types and codes for the bounded sorted-insert stack
// Request/result payloads, mode and error codes, and the command word that
// the sequencer broadcasts to the row of stack cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bsws_pkg;

  // Register map
  localparam int         LIMIT_W     = 5;
  localparam logic [4:0] LIMIT_RESET = 5'd16;
  localparam int         ADDR_W      = 2;
  localparam logic [1:0] ADDR_LIMIT  = 2'd0;

  // Request modes
  localparam logic [2:0] MODE_PUSH  = 3'd0;
  localparam logic [2:0] MODE_POP   = 3'd1;
  localparam logic [2:0] MODE_SPUSH = 3'd2;
  localparam logic [2:0] MODE_SORT  = 3'd3;
  localparam logic [2:0] MODE_REV   = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] popped;
    logic               popped_valid;
    logic [4:0]         count;
    logic               is_empty;
    logic               is_full;
    logic [1:0]         error;
  } rsp_t;

  // Operation applied by every cell in the same cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_SORT,
    OP_REV,
    OP_BUBBLE
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    logic      parity;   // even/odd neighbor pairing for sort and reverse
    logic      first;    // first bubble step of a sorted push
    logic      mark_in;  // marker for the word entering the top cell
  } cmd_t;

endpackage

`default_nettype wire

[design/bsws_cell.sv]
// ----------------------------------------------------------------------------
// bsws_cell: one stack entry
// Holds one word and an insert marker. Each cycle it keeps its word, takes
// the word of its upper or lower neighbor, or trades with a neighbor in a
// compare-exchange step, as the broadcast command says.
// ----------------------------------------------------------------------------
`default_nettype none

module bsws_cell #(
  parameter int IDX        = 0,
  parameter int WORD_WIDTH = 32,
  parameter int CNT_W      = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bsws_pkg::cmd_t               cmd,
  input  logic [CNT_W-1:0]             cnt,
  input  logic signed [WORD_WIDTH-1:0] up_word,
  input  logic                         up_mark,
  input  logic signed [WORD_WIDTH-1:0] dn_word,
  input  logic                         dn_mark,
  output logic signed [WORD_WIDTH-1:0] word,
  output logic                         mark
);
  import bsws_pkg::*;

  localparam logic             IS_ODD   = 1'(IDX % 2);
  localparam logic             HAS_UP   = (IDX > 0);
  localparam logic [CNT_W:0]   POS      = (CNT_W+1)'(IDX);
  localparam logic [CNT_W:0]   POS_NEXT = (CNT_W+1)'(IDX + 1);

  logic signed [WORD_WIDTH-1:0] word_r, word_nxt;
  logic                         mark_r, mark_nxt;
  logic                         dn_in_range, up_in_range;
  logic                         dn_gt, dn_ge, me_gt, me_ge;

  // Pair with the cell below / above lies inside the live entries
  assign dn_in_range = ({1'b0, cnt} > POS_NEXT);
  assign up_in_range = HAS_UP && ({1'b0, cnt} > POS);

  assign dn_gt = (dn_word > word_r);
  assign dn_ge = (dn_word >= word_r);
  assign me_gt = (word_r > up_word);
  assign me_ge = (word_r >= up_word);

  // Next word and marker
  always_comb begin
    word_nxt = word_r;
    mark_nxt = mark_r;
    unique case (cmd.op)
      OP_PUSH: begin
        word_nxt = up_word;
        mark_nxt = HAS_UP ? 1'b0 : up_mark;
      end
      OP_POP: begin
        word_nxt = dn_word;
        mark_nxt = dn_mark;
      end
      OP_SORT, OP_REV: begin
        if (cmd.parity == IS_ODD) begin
          // upper cell of its pair
          if (dn_in_range && (cmd.op == OP_REV || dn_gt)) begin
            word_nxt = dn_word;
            mark_nxt = dn_mark;
          end
        end else begin
          // lower cell of its pair
          if (up_in_range && (cmd.op == OP_REV || me_gt)) begin
            word_nxt = up_word;
            mark_nxt = up_mark;
          end
        end
      end
      OP_BUBBLE: begin
        // inserted word sinks below larger words; first step also below equal
        if (mark_r) begin
          if (dn_in_range && (cmd.first ? dn_ge : dn_gt)) begin
            word_nxt = dn_word;
            mark_nxt = dn_mark;
          end
        end else if (up_mark) begin
          if (up_in_range && (cmd.first ? me_ge : me_gt)) begin
            word_nxt = up_word;
            mark_nxt = up_mark;
          end
        end
      end
      default: ;
    endcase
  end

  // Word storage
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // Marker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= 1'b0;
    end else begin
      mark_r <= mark_nxt;
    end
  end

  assign word = word_r;
  assign mark = mark_r;

endmodule

`default_nettype wire

[design/bsws_ctrl.sv]
// ----------------------------------------------------------------------------
// bsws_ctrl: request sequencer and result register
// Checks each request against the occupancy and limit, drives the command
// for the cell row, counts the rounds of multi-cycle operations and issues
// one result strobe per request.
// ----------------------------------------------------------------------------
`default_nettype none

module bsws_ctrl #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32,
  parameter int CNT_W      = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  bsws_pkg::req_t                 in_req,
  input  logic [bsws_pkg::LIMIT_W-1:0]   limit,
  input  logic signed [WORD_WIDTH-1:0]   top_word,
  output logic signed [WORD_WIDTH-1:0]   push_word,
  output bsws_pkg::cmd_t                 cmd,
  output logic [CNT_W-1:0]               cnt,
  output logic                           out_valid,
  output bsws_pkg::rsp_t                 out_rsp
);
  import bsws_pkg::*;

  localparam int              CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  steps_r, steps_nxt;
  chain_op_t         run_op_r, run_op_nxt;
  logic              parity_r, parity_nxt;
  logic              first_r, first_nxt;
  rsp_t              rsp_r, rsp_nxt;
  logic              valid_r, valid_nxt;

  logic              full_now, full_after, go_run, pvalid;
  logic [1:0]        err;
  logic [CMP_W-1:0]  lim_ext;
  logic signed [63:0] top64, val64;

  // Word conversions between the 32-bit fields and the stored width
  assign val64     = 64'(in_req.value);
  assign push_word = val64[WORD_WIDTH-1:0];
  assign top64     = 64'(top_word);

  assign lim_ext  = CMP_W'(limit);
  assign full_now = (CMP_W'(cnt_r) >= lim_ext) || (cnt_r == CNT_MAX);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    steps_nxt  = steps_r;
    run_op_nxt = run_op_r;
    parity_nxt = parity_r;
    first_nxt  = first_r;
    rsp_nxt    = rsp_r;
    valid_nxt  = 1'b0;
    err        = ERR_OK;
    pvalid     = 1'b0;
    go_run     = 1'b0;
    full_after = 1'b0;
    cmd        = '{op: OP_HOLD, parity: parity_r, first: first_r, mark_in: 1'b0};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_req.mode)
            MODE_PUSH, MODE_SPUSH: begin
              if (full_now) begin
                err = ERR_FULL;
              end else begin
                cnt_nxt     = cnt_r + CNT_W'(1);
                cmd.op      = OP_PUSH;
                cmd.mark_in = (in_req.mode == MODE_SPUSH);
                if (in_req.mode == MODE_SPUSH && cnt_r != '0) begin
                  go_run     = 1'b1;
                  run_op_nxt = OP_BUBBLE;
                end
              end
            end
            MODE_POP: begin
              if (cnt_r == '0) begin
                err = ERR_EMPTY;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
                pvalid  = 1'b1;
                cmd.op  = OP_POP;
              end
            end
            MODE_SORT: begin
              if (cnt_r >= CNT_W'(2)) begin
                go_run     = 1'b1;
                run_op_nxt = OP_SORT;
              end
            end
            MODE_REV: begin
              if (cnt_r >= CNT_W'(2)) begin
                go_run     = 1'b1;
                run_op_nxt = OP_REV;
              end
            end
            default: ;
          endcase

          // one round per entry; steps counts the rounds still to run
          steps_nxt  = cnt_r;
          parity_nxt = 1'b0;
          first_nxt  = 1'b1;

          full_after = (CMP_W'(cnt_nxt) >= lim_ext) || (cnt_nxt == CNT_MAX);
          rsp_nxt.popped       = pvalid ? top64[31:0] : '0;
          rsp_nxt.popped_valid = pvalid;
          rsp_nxt.count        = 5'(cnt_nxt);
          rsp_nxt.is_empty     = (cnt_nxt == '0);
          rsp_nxt.is_full      = full_after;
          rsp_nxt.error        = err;

          if (go_run) begin
            state_nxt = ST_RUN;
          end else begin
            valid_nxt = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd.op     = run_op_r;
        steps_nxt  = steps_r - CNT_W'(1);
        parity_nxt = ~parity_r;
        first_nxt  = 1'b0;
        if (steps_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
          valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Round counter and held result
  always_ff @(posedge clk) begin
    steps_r  <= steps_nxt;
    run_op_r <= run_op_nxt;
    parity_r <= parity_nxt;
    first_r  <= first_nxt;
    rsp_r    <= rsp_nxt;
  end

  assign busy      = (state_r == ST_RUN);
  assign cnt       = cnt_r;
  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

endmodule

`default_nettype wire

[design/bounded_stack_with_sorted_insert_core.sv]
// ----------------------------------------------------------------------------
// bounded_stack_with_sorted_insert_core: bounded stack with sorted insert
// A row of cells holds the entries, top entry in cell 0. Push, pop, sorted
// push, sort (largest on top) and reverse; one result per request.
//
//   channel  | ports                               | handshake
//   ---------+-------------------------------------+----------------------------
//   request  | start, busy, in_req                 | taken when start && !busy
//   result   | out_valid, out_rsp                  | one-cycle strobe, no stall
//   config   | psel penable pwrite paddr pwdata... | APB write, pready tied high
//
// Push, pop, refused requests and no-ops leave busy low and run back to back; the
// result strobes the cycle after the request. Sorted push onto n entries keeps
// busy high while the new word sinks one cell per cycle; sort and reverse of n >= 2
// entries run n odd/even neighbor exchange rounds, busy all.
// The receiver cannot stall: every result is a one-cycle strobe.
// Reset leaves the stack empty and the limit at 16; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_with_sorted_insert_core #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  bsws_pkg::req_t                in_req,
  // result channel
  output logic                          out_valid,
  output bsws_pkg::rsp_t                out_rsp,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsws_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bsws_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [LIMIT_W-1:0]           limit_r;
  cmd_t                         cmd;
  logic [CNT_W-1:0]             cnt_w;
  logic signed [WORD_WIDTH-1:0] push_word;
  logic signed [WORD_WIDTH-1:0] word_w [DEPTH];
  logic                         mark_w [DEPTH];

  // Limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_LIMIT) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_LIMIT) ? 32'(limit_r) : '0;
  assign pready = 1'b1;

  // Sequencer
  bsws_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .limit     (limit_r),
    .top_word  (word_w[0]),
    .push_word (push_word),
    .cmd       (cmd),
    .cnt       (cnt_w),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  // Cell row: cell 0 is the top of the stack
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_WIDTH-1:0] up_word, dn_word;
    logic                         up_mark, dn_mark;

    if (g == 0) begin : g_head
      assign up_word = push_word;
      assign up_mark = cmd.mark_in;
    end else begin : g_body
      assign up_word = word_w[g-1];
      assign up_mark = mark_w[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign dn_word = '0;
      assign dn_mark = 1'b0;
    end else begin : g_link
      assign dn_word = word_w[g+1];
      assign dn_mark = mark_w[g+1];
    end

    bsws_cell #(
      .IDX        (g),
      .WORD_WIDTH (WORD_WIDTH),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .cnt     (cnt_w),
      .up_word (up_word),
      .up_mark (up_mark),
      .dn_word (dn_word),
      .dn_mark (dn_mark),
      .word    (word_w[g]),
      .mark    (mark_w[g])
    );
  end

  // Every accepted request either reports next cycle or starts its rounds
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("request neither reported nor running");

  // Results only leave once the rounds are done
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Occupancy stays within the cell row
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_w <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  // A reported pop removed exactly one entry without error
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.popped_valid) |->
      (out_rsp.error == ERR_OK && cnt_w == $past(cnt_w) - CNT_W'(1)))
    else $error("pop result does not match occupancy change");

endmodule

`default_nettype wire

[tb/bounded_stack_with_sorted_insert_core_test.sv]
// ----------------------------------------------------------------------------
// bounded_stack_with_sorted_insert_core_test: regression for the sorted stack
// Drives push, pop, sorted push, sort and reverse requests, with directed
// corner cases first and then randomized phases under varying limits. A
// shadow stack predicts each result; every strobed result is checked in order.
// ----------------------------------------------------------------------------

// Shadow stack plus queue of predicted results
class stack_scoreboard;
  localparam int STACK_DEPTH = 16;

  logic signed [31:0]  cells [STACK_DEPTH];  // index 0 is the bottom
  int                  occupancy;
  int                  limit;
  bsws_pkg::rsp_t      pending_rsp [$];
  int                  errors;

  function new();
    occupancy = 0;
    limit     = bsws_pkg::LIMIT_RESET;
    errors    = 0;
  endfunction

  function void set_limit(logic [31:0] v);
    limit = v[bsws_pkg::LIMIT_W-1:0];
  endfunction

  function int pending();
    return pending_rsp.size();
  endfunction

  // limit saturates at the physical depth
  function int effective_limit();
    return (limit > STACK_DEPTH) ? STACK_DEPTH : limit;
  endfunction

  // Apply one request to the shadow stack and return the expected result
  function bsws_pkg::rsp_t apply_request(bsws_pkg::req_t r);
    bsws_pkg::rsp_t     exp;
    logic signed [31:0] v;
    logic signed [31:0] t;
    int                 n;
    int                 k;
    int                 i;
    int                 j;
    exp = '0;
    v   = r.value;
    n   = occupancy;
    exp.error = bsws_pkg::ERR_OK;
    case (r.mode)
      bsws_pkg::MODE_PUSH, bsws_pkg::MODE_SPUSH: begin
        if (n >= effective_limit() || n >= STACK_DEPTH) begin
          exp.error = bsws_pkg::ERR_FULL;
        end else if (r.mode == bsws_pkg::MODE_PUSH || n == 0 || v > cells[n-1]) begin
          cells[n]  = v;
          occupancy = n + 1;
        end else begin
          // top is always lifted, then every entry strictly above the value
          k = n - 1;
          while (k > 0 && cells[k-1] > v) k--;
          for (i = n; i > k; i--) cells[i] = cells[i-1];
          cells[k]  = v;
          occupancy = n + 1;
        end
      end
      bsws_pkg::MODE_POP: begin
        if (n == 0) begin
          exp.error = bsws_pkg::ERR_EMPTY;
        end else begin
          exp.popped       = cells[n-1];
          exp.popped_valid = 1'b1;
          occupancy        = n - 1;
        end
      end
      bsws_pkg::MODE_SORT: begin
        // ascending from the bottom, largest ends on top
        for (i = 1; i < n; i++) begin
          t = cells[i];
          j = i;
          while (j > 0 && cells[j-1] > t) begin
            cells[j] = cells[j-1];
            j--;
          end
          cells[j] = t;
        end
      end
      bsws_pkg::MODE_REV: begin
        for (i = 0; i < n / 2; i++) begin
          t            = cells[i];
          cells[i]     = cells[n-1-i];
          cells[n-1-i] = t;
        end
      end
      default: ;  // unused modes leave the stack alone
    endcase
    exp.count    = occupancy[4:0];
    exp.is_empty = (occupancy == 0);
    exp.is_full  = (occupancy >= effective_limit());
    return exp;
  endfunction

  function void note_request(bsws_pkg::req_t r);
    pending_rsp.push_back(apply_request(r));
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(bsws_pkg::rsp_t got);
    bsws_pkg::rsp_t exp;
    if (pending_rsp.size() == 0) begin
      $error("result with no request outstanding: 0x%0h", got);
      errors++;
      return;
    end
    exp = pending_rsp.pop_front();
    compare_field("popped", exp.popped, got.popped);
    compare_field("popped_valid", exp.popped_valid, got.popped_valid);
    compare_field("count", exp.count, got.count);
    compare_field("is_empty", exp.is_empty, got.is_empty);
    compare_field("is_full", exp.is_full, got.is_full);
    compare_field("error", exp.error, got.error);
  endfunction
endclass

module bounded_stack_with_sorted_insert_core_test;
  import bsws_pkg::*;

  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         PHASES       = 16;
  localparam int         PHASE_ITEMS  = 100;
  localparam int         SETTLE       = 20;
  localparam logic [2:0] MODE_UNUSED  = 3'd7;
  localparam logic [31:0] WORD_MAX    = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN    = 32'h8000_0000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  req_t              in_req;
  logic              out_valid;
  rsp_t              out_rsp;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  stack_scoreboard   sb;
  int                cycles = 0;

  bounded_stack_with_sorted_insert_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bounded_stack_with_sorted_insert_core regression: fail");
      $finish;
    end
  end

  // Result monitor: strobe is taken at the edge that ends its cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_rsp);
  end

  function automatic req_t make_request(logic [2:0] mode, logic [31:0] value);
    req_t r;
    r.mode  = mode;
    r.value = value;
    return r;
  endfunction

  // Random request; push_w and pop_w are percentages, sort/reverse/unused fill the rest
  function automatic req_t random_request(int push_w, int pop_w);
    int          pick;
    int          kind;
    logic [2:0]  mode;
    logic [31:0] value;
    pick = $urandom_range(0, 99);
    if (pick < push_w)                 mode = ($urandom_range(0, 1) != 0) ? MODE_SPUSH : MODE_PUSH;
    else if (pick < push_w + pop_w)    mode = MODE_POP;
    else if (pick < push_w + pop_w + 6)  mode = MODE_SORT;
    else if (pick < push_w + pop_w + 12) mode = MODE_REV;
    else                               mode = 3'($urandom_range(5, 7));
    kind = $urandom_range(0, 9);
    case (kind)
      0:       value = WORD_MAX;
      1:       value = WORD_MIN;
      2, 3, 4: value = 32'($signed($urandom_range(0, 15)) - 8);  // dense, many ties
      default: value = $urandom;
    endcase
    return make_request(mode, value);
  endfunction

  // Hold start with the request until the block takes it
  task automatic send_request(input req_t r);
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending until every predicted result has been checked
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  // Register write in setup and access phases; lands at the access-phase edge
  task automatic write_limit(input logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_LIMIT;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_limit(v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_phase(input int phase);
    int   push_w;
    int   gap_max;
    int   left;
    int   burst;
    req_t r;
    wait_drained();
    if (phase == 0)      write_limit(32'd16);
    else if (phase == 1) write_limit(32'd1);
    else begin
      case ($urandom_range(0, 9))
        0:       write_limit(32'd0);
        1:       write_limit(32'd1);
        2:       write_limit(32'd16);
        3:       write_limit(32'($urandom_range(17, 31)));  // saturates at depth
        default: write_limit(32'($urandom_range(1, 16)));
      endcase
    end
    case ($urandom_range(0, 2))
      0:       push_w = 30;
      1:       push_w = 45;
      default: push_w = 60;
    endcase
    gap_max = (phase % 4 == 0) ? 0 : $urandom_range(1, 8);
    left    = PHASE_ITEMS;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        r = random_request(push_w, 85 - push_w);
        send_request(r);
        if (r.mode <= MODE_REV) left--;
        burst--;
      end
      if ($urandom_range(0, 11) == 0) wait_drained();
      else idle_cycles($urandom_range(0, gap_max));
    end
  endtask

  initial begin
    sb = new();
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_req  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty stack, extremes, sorted insert below and among equals
    send_request(make_request(MODE_POP, 32'd0));
    send_request(make_request(MODE_SORT, 32'd0));
    send_request(make_request(MODE_REV, 32'd0));
    send_request(make_request(MODE_PUSH, WORD_MAX));
    send_request(make_request(MODE_SORT, 32'd0));
    send_request(make_request(MODE_REV, 32'd0));
    send_request(make_request(MODE_PUSH, WORD_MIN));
    send_request(make_request(MODE_SPUSH, 32'd0));
    send_request(make_request(MODE_SPUSH, 32'hffff_ffff));
    send_request(make_request(MODE_SPUSH, 32'd0));
    send_request(make_request(MODE_SPUSH, WORD_MIN));
    send_request(make_request(MODE_SORT, 32'd0));
    send_request(make_request(MODE_REV, 32'd0));
    send_request(make_request(MODE_UNUSED, 32'hdead_beef));
    send_request(make_request(MODE_POP, 32'd0));
    send_request(make_request(MODE_POP, 32'd0));

    // Limit lowered under the current count: pushes refused, pops still work
    wait_drained();
    write_limit(32'd1);
    send_request(make_request(MODE_PUSH, 32'd7));
    send_request(make_request(MODE_SPUSH, 32'd7));
    send_request(make_request(MODE_POP, 32'd0));

    // Zero limit: full at once
    wait_drained();
    write_limit(32'd0);
    send_request(make_request(MODE_POP, 32'd0));
    send_request(make_request(MODE_PUSH, 32'd1));

    // Limit above depth saturates
    wait_drained();
    write_limit(32'd31);
    send_request(make_request(MODE_PUSH, 32'h5555_aaaa));
    send_request(make_request(MODE_SPUSH, 32'haaaa_5555));

    for (int p = 0; p < PHASES; p++) random_phase(p);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("bounded_stack_with_sorted_insert_core regression: pass");
    end else begin
      $display("bounded_stack_with_sorted_insert_core regression: fail");
    end
    $finish;
  end

endmodule
